// ----- rtl/phm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm_pkg: shared types and constants of the pixel histogram
// field widths of the streams, command queue format and code names
// ----------------------------------------------------------------------------
package phm_pkg;

	// fixed widths of the stream fields
	localparam int PIX_W = 16;
	localparam int CNT_W = 24;

	// defaults of the top level parameters
	localparam int VALUE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 24;

	// frame tag kept next to every bin count
	localparam int EPOCH_BITS = 8;
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};

	// depth of the command queue between front and back end
	localparam int CMD_DEPTH = 4;

	// item operation codes
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result kinds
	localparam logic KIND_MODE = 1'b0;
	localparam logic KIND_BIN = 1'b1;

	typedef struct packed {
		logic is_read;
		logic frame_start;
		logic last;
		logic [PIX_W-1:0] addr;
	} phm_cmd_t;

	typedef struct packed {
		logic init_busy;
	} phm_back_status_t;

endpackage

// ----- rtl/phm_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm stream interfaces
// valid/ready channels for pixel items and histogram results
// ----------------------------------------------------------------------------
interface phm_item_if;
	logic valid;
	logic ready;
	logic op;
	logic [phm_pkg::PIX_W-1:0] pixel_or_bin;
	logic last_pixel;

	modport source (output valid, op, pixel_or_bin, last_pixel, input ready);
	modport sink (input valid, op, pixel_or_bin, last_pixel, output ready);
endinterface

interface phm_result_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [phm_pkg::PIX_W-1:0] mode_value;
	logic [phm_pkg::CNT_W-1:0] mode_count;
	logic [phm_pkg::CNT_W-1:0] bin_count;

	modport source (output valid, result_kind, mode_value, mode_count, bin_count,
		input ready);
	modport sink (input valid, result_kind, mode_value, mode_count, bin_count,
		output ready);
endinterface

// ----- rtl/phm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm_front: item intake and classification
// drops disabled pixels, tracks frame boundaries, queues commands
// ----------------------------------------------------------------------------
module phm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accumulate_enable,
	input  phm_pkg::phm_back_status_t  back_status,
	input  logic                       cmd_full,
	phm_item_if.sink                   items,
	output logic                       cmd_push,
	output phm_pkg::phm_cmd_t          cmd
);

	logic frame_open_q;
	logic accept;
	logic counted;

	assign items.ready = !back_status.init_busy && !cmd_full;
	assign accept = items.valid && items.ready;
	assign counted = (items.op == phm_pkg::OP_ACCUM) && accumulate_enable;

	// reads always go through, pixels only while counting is enabled
	assign cmd_push = accept && ((items.op == phm_pkg::OP_READ) || accumulate_enable);

	always_comb begin
		cmd.is_read = (items.op == phm_pkg::OP_READ);
		cmd.frame_start = counted && !frame_open_q;
		cmd.last = counted && items.last_pixel;
		cmd.addr = items.pixel_or_bin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (accept && counted) begin
			frame_open_q <= !items.last_pixel;
		end
	end

endmodule

// ----- rtl/phm_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm_cmd_fifo: short command queue
// decouples the intake from the histogram back end
// ----------------------------------------------------------------------------
module phm_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  phm_pkg::phm_cmd_t  wdata,
	input  logic               pop,
	output phm_pkg::phm_cmd_t  head,
	output logic               head_valid,
	output logic               full
);

	localparam int PTR_W = $clog2(phm_pkg::CMD_DEPTH);
	localparam int CNT_W = $clog2(phm_pkg::CMD_DEPTH + 1);

	phm_pkg::phm_cmd_t entries_q [phm_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head = entries_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full = (count_q == CNT_W'(phm_pkg::CMD_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("command popped from an empty queue");

endmodule

// ----- rtl/phm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phm_back: bin memory, read-modify-write pipeline and running mode
// frame tags make a new frame read as empty; tag wrap forces a clearing pass
// ----------------------------------------------------------------------------
module phm_back #(
	parameter int VALUE_BITS = phm_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = phm_pkg::COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  phm_pkg::phm_cmd_t          head,
	input  logic                       head_valid,
	output logic                       pop,
	output phm_pkg::phm_back_status_t  status,
	phm_result_if.source               results
);

	localparam int EB = phm_pkg::EPOCH_BITS;
	localparam int WORD_BITS = EB + COUNT_BITS;
	localparam int NUM_BINS = 2 ** VALUE_BITS;
	localparam int OUT_VAL_W = phm_pkg::PIX_W;
	localparam int OUT_CNT_W = phm_pkg::CNT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0] LAST_BIN = {VALUE_BITS{1'b1}};

	logic [WORD_BITS-1:0] mem [NUM_BINS];

	// clearing pass and frame tag
	logic                  sweep_q;
	logic                  init_q;
	logic [VALUE_BITS-1:0] sweep_idx_q;
	logic [EB-1:0]         epoch_q;

	// stage 1
	logic                  valid_s1;
	logic                  is_read_s1;
	logic                  frame_start_s1;
	logic                  last_s1;
	logic [VALUE_BITS-1:0] addr_s1;
	logic [EB-1:0]         epoch_s1;
	logic                  fwd_hit_s1;
	logic [WORD_BITS-1:0]  rdata_s1;

	logic [WORD_BITS-1:0]  fwd_word_q;
	logic [COUNT_BITS-1:0] best_count_q;
	logic [VALUE_BITS-1:0] best_value_q;

	logic                  res_valid_q;
	logic                  res_kind_q;
	logic [OUT_VAL_W-1:0]  res_value_q;
	logic [OUT_CNT_W-1:0]  res_mode_cnt_q;
	logic [OUT_CNT_W-1:0]  res_bin_cnt_q;

	logic                  need_sweep;
	logic                  sweep_start;
	logic                  has_result;
	logic                  advance;
	logic [VALUE_BITS-1:0] head_addr;
	logic [WORD_BITS-1:0]  word;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] inc;
	logic                  sat;
	logic                  s1_wr;
	logic [COUNT_BITS-1:0] base_count;
	logic [VALUE_BITS-1:0] base_value;
	logic [COUNT_BITS-1:0] new_best_count;
	logic [VALUE_BITS-1:0] new_best_value;
	logic                  mem_we;
	logic [VALUE_BITS-1:0] mem_waddr;
	logic [WORD_BITS-1:0]  mem_wdata;

	assign head_addr = head.addr[VALUE_BITS-1:0];
	assign status.init_busy = init_q;

	// a frame start with the tag at its top needs every bin cleared first
	assign need_sweep = head.frame_start && (epoch_q == phm_pkg::EPOCH_MAX);
	assign sweep_start = head_valid && need_sweep && !valid_s1 && !sweep_q;

	assign has_result = is_read_s1 || last_s1;
	assign advance = valid_s1 && (!has_result || !res_valid_q || results.ready);
	assign pop = head_valid && !sweep_q && !need_sweep && (!valid_s1 || advance);

	// bin value seen by the stage 1 item
	always_comb begin
		word = fwd_hit_s1 ? fwd_word_q : rdata_s1;
		if (!frame_start_s1 && (word[WORD_BITS-1 -: EB] == epoch_s1)) begin
			cur = word[COUNT_BITS-1:0];
		end else begin
			cur = '0;
		end
		sat = (cur == COUNT_MAX);
		inc = cur + COUNT_BITS'(1);
		s1_wr = advance && !is_read_s1 && !sat;
	end

	// running mode, strictly greater replaces
	always_comb begin
		base_count = frame_start_s1 ? '0 : best_count_q;
		base_value = frame_start_s1 ? '0 : best_value_q;
		if (!sat && (inc > base_count)) begin
			new_best_count = inc;
			new_best_value = addr_s1;
		end else begin
			new_best_count = base_count;
			new_best_value = base_value;
		end
	end

	always_comb begin
		mem_we = sweep_q || s1_wr;
		mem_waddr = sweep_q ? sweep_idx_q : addr_s1;
		mem_wdata = sweep_q ? '0 : {epoch_s1, inc};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_s1 <= mem[head_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_wr) begin
			fwd_word_q <= {epoch_s1, inc};
		end
		if (pop) begin
			is_read_s1 <= head.is_read;
			frame_start_s1 <= head.frame_start;
			last_s1 <= head.last;
			addr_s1 <= head_addr;
			epoch_s1 <= head.frame_start ? epoch_q + EB'(1) : epoch_q;
			fwd_hit_s1 <= s1_wr && (addr_s1 == head_addr);
		end
		if (advance && has_result) begin
			if (is_read_s1) begin
				res_kind_q <= phm_pkg::KIND_BIN;
				res_value_q <= '0;
				res_mode_cnt_q <= '0;
				res_bin_cnt_q <= OUT_CNT_W'(cur);
			end else begin
				res_kind_q <= phm_pkg::KIND_MODE;
				res_value_q <= OUT_VAL_W'(new_best_value);
				res_mode_cnt_q <= OUT_CNT_W'(new_best_count);
				res_bin_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= 1'b1;
			init_q <= 1'b1;
			sweep_idx_q <= '0;
			epoch_q <= phm_pkg::EPOCH_FIRST;
			valid_s1 <= 1'b0;
			best_count_q <= '0;
			best_value_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (sweep_q) begin
				sweep_idx_q <= sweep_idx_q + VALUE_BITS'(1);
				if (sweep_idx_q == LAST_BIN) begin
					sweep_q <= 1'b0;
					init_q <= 1'b0;
					epoch_q <= phm_pkg::EPOCH_FIRST;
				end
			end else if (sweep_start) begin
				sweep_q <= 1'b1;
			end else if (pop && head.frame_start) begin
				epoch_q <= epoch_q + EB'(1);
			end

			valid_s1 <= pop || (valid_s1 && !advance);

			if (advance && !is_read_s1) begin
				best_count_q <= new_best_count;
				best_value_q <= new_best_value;
			end

			if (advance && has_result) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid = res_valid_q;
	assign results.result_kind = res_kind_q;
	assign results.mode_value = res_value_q;
	assign results.mode_count = res_mode_cnt_q;
	assign results.bin_count = res_bin_cnt_q;

	a_sweep_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweep_q && valid_s1))
		else $error("clearing pass overlaps a stage 1 item");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("frame tag reached the cleared code");

	a_epoch_track: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (epoch_s1 == epoch_q))
		else $error("stage 1 item carries a stale frame tag");

endmodule

// ----- rtl/pixel_histogram_with_mode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_histogram_with_mode: pixel value histogram with running mode
// counts pixels per value, reports the frame mode and answers bin reads
// ----------------------------------------------------------------------------
// the block takes one item and gives one result per clock when no sweep
// runs, the queue has room and the sink is ready; each counted pixel is one
// read-modify-write on the single bin memory write port, which sets the
// rate. an item passes the command queue, stage 1 and the result register
// before its result leaves. after reset all 2**VALUE_BITS bins (65536 by
// default) are swept and items are refused during that pass. bins carry an
// 8-bit frame tag, so a new frame is empty at once; the first pixel of the
// 255th frame after reset, and of every 254th frame after that, waits for
// another sweep in the back end while the intake keeps filling the 4-entry
// queue. a read item returns the bin count as it stands, also mid-frame.
// with accumulate_enable low pixels give no transaction and change nothing.
// ----------------------------------------------------------------------------
module pixel_histogram_with_mode #(
	parameter int VALUE_BITS = phm_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = phm_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	phm_item_if.sink      items,
	phm_result_if.source  results
);

	// accumulate enable register, on after reset
	logic accumulate_enable_q;

	// front to queue
	logic              cmd_push;
	phm_pkg::phm_cmd_t cmd;
	logic              cmd_full;

	// queue to back end
	phm_pkg::phm_cmd_t head;
	logic              head_valid;
	logic              pop;

	// back end status toward the intake
	phm_pkg::phm_back_status_t back_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accumulate_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			accumulate_enable_q <= cfg_wr_data;
		end
	end

	// intake: classifies each transaction, marks frame start and end
	phm_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accumulate_enable (accumulate_enable_q),
		.back_status       (back_status),
		.cmd_full          (cmd_full),
		.items             (items),
		.cmd_push          (cmd_push),
		.cmd               (cmd)
	);

	// short queue so intake and back end stall independently
	phm_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.wdata      (cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (cmd_full)
	);

	// back end: bin memory, mode tracking, result register
	phm_back #(
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.status     (back_status),
		.results    (results)
	);

endmodule

// ----- tb/sv/pixel_histogram_with_mode_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_histogram_with_mode_test: self-checking bench of the pixel histogram
// drives pixel and bin read transactions, predicts every mode report and bin
// read in a behavioral histogram kept alongside, and compares each result
// transaction field by field under varying source and sink idling
// ----------------------------------------------------------------------------
module pixel_histogram_with_mode_test;

	localparam int PIX_W = phm_pkg::PIX_W;
	localparam int CNT_W = phm_pkg::CNT_W;
	localparam logic [CNT_W-1:0] BIN_CEILING = {CNT_W{1'b1}};

	// one predicted result transaction
	typedef struct {
		logic kind;
		logic [PIX_W-1:0] value;
		logic [CNT_W-1:0] peak;
		logic [CNT_W-1:0] bin;
	} hist_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	phm_item_if items ();
	phm_result_if results ();

	pixel_histogram_with_mode u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.items(items),
		.results(results)
	);

	// behavioral copy of the histogram, its running mode and the enable
	logic [CNT_W-1:0] pixel_bins [logic [PIX_W-1:0]];
	logic [CNT_W-1:0] mode_cnt = '0;
	logic [PIX_W-1:0] mode_val = '0;
	logic frame_live = 1'b0;
	logic accum_en = 1'b1;

	// results predicted and not yet seen, oldest first
	hist_result_t due_results [$];
	hist_result_t oldest_due;

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// hold-off request from the tests, taken up by the sink process
	int hold_off_len = 0;
	int hold_off_req = 0;
	int hold_off_seen = 0;
	int hold_off_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous ceiling: two bin memory sweeps plus all traffic, many times over
	initial begin
		#8ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// sink side: random stalls, or a long hold-off counted down here
	always @(posedge clk) begin
		if (hold_off_req != hold_off_seen) begin
			hold_off_seen = hold_off_req;
			hold_off_left = hold_off_len;
		end
		if (hold_off_left > 0) begin
			results.ready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			results.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d value 0x%0h",
					$time, results.result_kind, results.mode_value);
				errors++;
			end else begin
				oldest_due = due_results.pop_front();
				check_field("result_kind", 32'(oldest_due.kind), 32'(results.result_kind));
				check_field("mode_value", 32'(oldest_due.value), 32'(results.mode_value));
				check_field("mode_count", 32'(oldest_due.peak), 32'(results.mode_count));
				check_field("bin_count", 32'(oldest_due.bin), 32'(results.bin_count));
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	// apply one accepted transaction to the histogram copy
	function automatic void histogram_step(input logic op, input logic [PIX_W-1:0] v,
		input logic last);
		hist_result_t r;
		logic [CNT_W-1:0] c;
		if (op == phm_pkg::OP_READ) begin
			// read answers the live count, last flag has no effect
			r.kind = phm_pkg::KIND_BIN;
			r.value = '0;
			r.peak = '0;
			r.bin = pixel_bins.exists(v) ? pixel_bins[v] : '0;
			due_results.push_back(r);
			return;
		end
		if (!accum_en)
			return;
		// first counted pixel of a frame wipes the histogram and the mode
		if (!frame_live) begin
			pixel_bins.delete();
			mode_cnt = '0;
			mode_val = '0;
			frame_live = 1'b1;
		end
		c = pixel_bins.exists(v) ? pixel_bins[v] : '0;
		// saturated bins stay put; ties keep the earlier mode
		if (c != BIN_CEILING) begin
			c = c + CNT_W'(1);
			pixel_bins[v] = c;
			if (c > mode_cnt) begin
				mode_cnt = c;
				mode_val = v;
			end
		end
		if (last) begin
			frame_live = 1'b0;
			r.kind = phm_pkg::KIND_MODE;
			r.value = mode_val;
			r.peak = mode_cnt;
			r.bin = '0;
			due_results.push_back(r);
		end
	endfunction

	// offer one transaction, with random idle cycles ahead of it
	task automatic send_item(input logic op, input logic [PIX_W-1:0] v, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid <= 1'b1;
		items.op <= op;
		items.pixel_or_bin <= v;
		items.last_pixel <= last;
		do
			@(posedge clk);
		while (!items.ready);
		histogram_step(op, v, last);
	endtask

	// source goes quiet until every predicted result is in
	task automatic wait_drained();
		items.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// a trailing read proves the pipeline empty before the register changes
	task automatic set_accumulate(input logic en);
		send_item(phm_pkg::OP_READ, PIX_W'($urandom), 1'b0);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= en;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		accum_en = en;
	endtask

	// short frames over a small per-frame palette so counts climb and tie
	task automatic run_random_frames(input int n_items);
		logic [PIX_W-1:0] palette [4];
		logic [PIX_W-1:0] v;
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			foreach (palette[i])
				palette[i] = PIX_W'($urandom);
			len = $urandom_range(1, 10);
			for (int p = 0; p < len; p++) begin
				if ($urandom_range(9) < 7)
					v = palette[$urandom_range(3)];
				else
					v = PIX_W'($urandom);
				send_item(phm_pkg::OP_ACCUM, v, p == len - 1);
				sent++;
				// reads land mid-frame or between frames and carry a random last flag
				if ($urandom_range(4) == 0) begin
					if ($urandom_range(1) == 1)
						v = palette[$urandom_range(3)];
					else
						v = PIX_W'($urandom);
					send_item(phm_pkg::OP_READ, v, 1'($urandom));
					sent++;
				end
			end
		end
	endtask

	// bins are empty after reset, at both ends of the range
	task automatic test_reset_reads();
		send_item(phm_pkg::OP_READ, '0, 1'b0);
		send_item(phm_pkg::OP_READ, '1, 1'b1);
		send_item(phm_pkg::OP_READ, 16'h8001, 1'b0);
	endtask

	// equal counts: the value that got there first keeps the mode
	task automatic test_tie_mode();
		send_item(phm_pkg::OP_ACCUM, 16'h0005, 1'b0);
		send_item(phm_pkg::OP_ACCUM, 16'h0003, 1'b0);
		send_item(phm_pkg::OP_ACCUM, 16'h0003, 1'b0);
		send_item(phm_pkg::OP_ACCUM, 16'h0005, 1'b1);
		send_item(phm_pkg::OP_READ, 16'h0005, 1'b0);
		send_item(phm_pkg::OP_READ, 16'h0003, 1'b0);
	endtask

	// a new frame starts from an empty histogram
	task automatic test_frame_clear();
		send_item(phm_pkg::OP_ACCUM, 16'hFFFF, 1'b1);
		send_item(phm_pkg::OP_READ, 16'h0003, 1'b0);
	endtask

	// reads see the running count while the frame is still open
	task automatic test_open_frame_read();
		send_item(phm_pkg::OP_ACCUM, 16'hA5A5, 1'b0);
		send_item(phm_pkg::OP_ACCUM, 16'h5A5A, 1'b0);
		send_item(phm_pkg::OP_READ, 16'hA5A5, 1'b0);
		send_item(phm_pkg::OP_ACCUM, 16'h0000, 1'b1);
	endtask

	// with counting off, pixels vanish even when flagged last
	task automatic test_disabled_pixels();
		set_accumulate(1'b0);
		send_item(phm_pkg::OP_ACCUM, 16'h1234, 1'b1);
		send_item(phm_pkg::OP_ACCUM, 16'h0000, 1'b0);
		send_item(phm_pkg::OP_READ, 16'h0000, 1'b0);
		send_item(phm_pkg::OP_READ, 16'h1234, 1'b0);
		set_accumulate(1'b1);
	endtask

	// sink holds off long enough to fill the queue and stall the intake
	task automatic test_backpressure();
		hold_off_len = 400;
		hold_off_req++;
		run_random_frames(30);
		wait_drained();
	endtask

	task automatic test_random_phases();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_frames(450);
		send_idle_pct = 62;
		run_random_frames(450);
		// counting switched off for a burst, reads still answered
		set_accumulate(1'b0);
		run_random_frames(40);
		set_accumulate(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 62;
		run_random_frames(450);
		send_idle_pct = 23;
		recv_stall_pct = 23;
		run_random_frames(450);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		items.valid = 1'b0;
		items.op = phm_pkg::OP_ACCUM;
		items.pixel_or_bin = '0;
		items.last_pixel = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// items wait out the post-reset sweep on the handshake
		test_reset_reads();
		test_tie_mode();
		test_frame_clear();
		test_open_frame_read();
		test_disabled_pixels();
		test_backpressure();
		test_random_phases();

		// closing read, then let the pipeline settle
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(phm_pkg::OP_READ, PIX_W'($urandom), 1'b0);
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0 && due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
